// ----- design/lru_page_store_with_backing_assert.svh -----
// Assertion macros for the LRU page store.
`ifndef LRU_PAGE_STORE_WITH_BACKING_ASSERT_SVH
`define LRU_PAGE_STORE_WITH_BACKING_ASSERT_SVH
`define LPS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define LPS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- design/lps_pkg.sv -----
//------------------------------------------------------------------------------
// lps_pkg
// Types and constants shared by the LRU page store modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package lps_pkg;
    localparam int MAIN_ENTRIES_DEF    = 16;
    localparam int BACKING_ENTRIES_DEF = 256;
    localparam logic [1:0] OP_STORE   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_DROP    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MFIND, S_MSHIFT, S_BSCAN, S_BWAIT, S_VSCAN,
        S_VPUSH, S_VSHIFT, S_APPEND, S_DONE
    } t_state;

    typedef struct packed {
        logic load;       // capture request, initialise scan indices
        logic mf_step;    // main find one entry
        logic ms_step;    // main shift one entry
        logic ms_start;   // start shift at found index
        logic bs_step;    // backing compaction one read
        logic bs_start;
        logic vs_start;
        logic vs_step;    // victim scan one entry
        logic vpush;      // push victim to backing
        logic vs_shift_start;
        logic append;
        logic touch;      // refresh stamp on main hit
        logic dec_main;
        logic res_set;    // result register valid
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic mf_done;
        logic mf_hit;
        logic ms_done;
        logic bs_done;
        logic bs_hit;
        logic vs_done;
        logic need_evict;
    } t_stat;
endpackage

// ----- design/lps_if.sv -----
//------------------------------------------------------------------------------
// lps_if
// Valid/ready channel carrying one request or one result.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lps_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] wdata;
    logic [30:0] now;
    modport source (output valid, op, key, wdata, now, input ready);
    modport sink (input valid, op, key, wdata, now, output ready);
endinterface

interface lps_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] rdata;
    logic        swapped;
    logic [31:0] evicted_key;
    modport source (output valid, status, rdata, swapped, evicted_key, input ready);
    modport sink (input valid, status, rdata, swapped, evicted_key, output ready);
endinterface

// ----- design/lps_ctrl.sv -----
//------------------------------------------------------------------------------
// lps_ctrl
// Sequencer for find, compaction, eviction and append steps.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_op,
    input  logic           i_res_free,
    input  lps_pkg::t_stat i_stat,
    output lps_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    lps_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lps_pkg::S_IDLE: begin
                if (i_start) n_state = (i_op == lps_pkg::OP_STORE) ?
                    lps_pkg::S_VSCAN : lps_pkg::S_MFIND;
                if (i_start && i_op != lps_pkg::OP_STORE &&
                    i_op != lps_pkg::OP_RELEASE && i_op != lps_pkg::OP_LOOKUP)
                    n_state = lps_pkg::S_DONE;
            end
            lps_pkg::S_MFIND: begin
                if (i_stat.mf_hit) begin
                    n_state = (i_stat.op == lps_pkg::OP_RELEASE) ?
                        lps_pkg::S_MSHIFT : lps_pkg::S_DONE;
                end else if (i_stat.mf_done) begin
                    n_state = lps_pkg::S_BSCAN;
                end
            end
            lps_pkg::S_MSHIFT: if (i_stat.ms_done) n_state = lps_pkg::S_DONE;
            lps_pkg::S_BSCAN:  if (i_stat.bs_done) n_state = lps_pkg::S_BWAIT;
            lps_pkg::S_BWAIT: begin
                if (i_stat.op == lps_pkg::OP_LOOKUP && i_stat.bs_hit)
                    n_state = lps_pkg::S_VSCAN;
                else n_state = lps_pkg::S_DONE;
            end
            lps_pkg::S_VSCAN: begin
                if (!i_stat.need_evict) n_state = lps_pkg::S_APPEND;
                else if (i_stat.vs_done) n_state = lps_pkg::S_VPUSH;
            end
            lps_pkg::S_VPUSH:  n_state = lps_pkg::S_VSHIFT;
            lps_pkg::S_VSHIFT: if (i_stat.ms_done) n_state = lps_pkg::S_APPEND;
            lps_pkg::S_APPEND: n_state = lps_pkg::S_DONE;
            lps_pkg::S_DONE:   if (i_res_free) n_state = lps_pkg::S_IDLE;
            default:           n_state = lps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != lps_pkg::S_IDLE);
        case (r_state)
            lps_pkg::S_IDLE:   o_cmd.load = i_start;
            lps_pkg::S_MFIND: begin
                o_cmd.mf_step = 1'b1;
                o_cmd.touch = i_stat.mf_hit && (i_stat.op == lps_pkg::OP_LOOKUP);
                o_cmd.ms_start = i_stat.mf_hit;
                o_cmd.bs_start = !i_stat.mf_hit && i_stat.mf_done;
            end
            lps_pkg::S_MSHIFT: begin
                o_cmd.ms_step = 1'b1;
                o_cmd.dec_main = i_stat.ms_done;
            end
            lps_pkg::S_BSCAN:  o_cmd.bs_step = 1'b1;
            lps_pkg::S_BWAIT:  o_cmd.vs_start = 1'b1;
            lps_pkg::S_VSCAN:  o_cmd.vs_step = 1'b1;
            lps_pkg::S_VPUSH: begin
                o_cmd.vpush = 1'b1;
                o_cmd.vs_shift_start = 1'b1;
            end
            lps_pkg::S_VSHIFT: begin
                o_cmd.ms_step = 1'b1;
                o_cmd.dec_main = i_stat.ms_done;
            end
            lps_pkg::S_APPEND: o_cmd.append = 1'b1;
            lps_pkg::S_DONE:   o_cmd.res_set = i_res_free;
            default:           o_cmd = '0;
        endcase
    end
endmodule

// ----- design/lps_dpath.sv -----
//------------------------------------------------------------------------------
// lps_dpath
// Main store registers, backing memory, scan counters and result fields.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lps_dpath #(
    parameter int MAIN_ENTRIES    = lps_pkg::MAIN_ENTRIES_DEF,
    parameter int BACKING_ENTRIES = lps_pkg::BACKING_ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [4:0]     i_pages,
    input  logic [1:0]     i_op,
    input  logic [31:0]    i_key,
    input  logic [31:0]    i_wdata,
    input  logic [30:0]    i_now,
    input  lps_pkg::t_cmd  i_cmd,
    output lps_pkg::t_stat o_stat,
    output logic [1:0]     o_status,
    output logic [31:0]    o_rdata,
    output logic           o_swapped,
    output logic [31:0]    o_evicted_key
);
    localparam int MW = $clog2(MAIN_ENTRIES + 1);
    localparam int MI = (MAIN_ENTRIES > 1) ? $clog2(MAIN_ENTRIES) : 1;
    localparam int BW = $clog2(BACKING_ENTRIES + 1);
    localparam int BI = (BACKING_ENTRIES > 1) ? $clog2(BACKING_ENTRIES) : 1;

    logic [31:0] r_mkey [MAIN_ENTRIES];
    logic [31:0] r_mval [MAIN_ENTRIES];
    logic [30:0] r_mstp [MAIN_ENTRIES];
    logic [MW-1:0] r_mcnt;
    logic [31:0] r_bkey [BACKING_ENTRIES];
    logic [31:0] r_bval [BACKING_ENTRIES];
    logic [BW-1:0] r_bcnt;

    logic [1:0]  r_op;
    logic [31:0] r_key, r_val;
    logic [30:0] r_now;
    logic [MW-1:0] r_mi, r_vi;
    logic [BW-1:0] r_rd, r_wr;
    logic        r_rdv, r_bhit;
    logic [31:0] r_rk, r_rv;
    logic [1:0]  r_status;
    logic        r_swapped;
    logic [31:0] r_ekey;
    logic [31:0] r_rdata;
    logic [MW-1:0] w_cap;
    logic [MW-1:0] w_next;

    always_comb begin
        w_cap = MW'(MAIN_ENTRIES);
        if (i_pages == 5'd0) w_cap = MW'(1);
        else if (32'(i_pages) < 32'(MAIN_ENTRIES)) w_cap = MW'(i_pages);
    end
    assign w_next = r_mi + MW'(1);

    assign o_stat.op = r_op;
    assign o_stat.mf_done = (r_mi >= r_mcnt);
    assign o_stat.mf_hit = (r_mi < r_mcnt) && (r_mkey[r_mi[MI-1:0]] == r_key);
    assign o_stat.ms_done = (w_next >= r_mcnt);
    assign o_stat.bs_done = (r_rd >= r_bcnt) && !r_rdv;
    assign o_stat.bs_hit = r_bhit;
    assign o_stat.vs_done = (r_mi >= r_mcnt);
    assign o_stat.need_evict = (r_mcnt >= w_cap) && (r_mcnt != '0);

    // Backing memory: one read port, one write port.
    always_ff @(posedge i_clk) begin
        r_rk <= r_bkey[r_rd[BI-1:0]];
        r_rv <= r_bval[r_rd[BI-1:0]];
        if (r_rdv && r_rk != r_key) begin
            r_bkey[r_wr[BI-1:0]] <= r_rk;
            r_bval[r_wr[BI-1:0]] <= r_rv;
        end else if (i_cmd.vpush && r_bcnt < BW'(BACKING_ENTRIES)) begin
            r_bkey[r_bcnt[BI-1:0]] <= r_mkey[r_vi[MI-1:0]];
            r_bval[r_bcnt[BI-1:0]] <= r_mval[r_vi[MI-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_key <= i_key; r_val <= i_wdata; r_now <= i_now;
            r_mi <= (i_op == lps_pkg::OP_STORE) ? MW'(1) : '0; r_vi <= '0;
            r_status <= lps_pkg::ST_OK; r_swapped <= 1'b0;
            r_ekey <= '0; r_bhit <= 1'b0;
            r_rdata <= '0;
        end
        if (i_cmd.mf_step && !o_stat.mf_hit && !o_stat.mf_done) r_mi <= w_next;
        if (i_cmd.touch) begin
            r_mstp[r_mi[MI-1:0]] <= r_now;
            r_rdata <= r_mval[r_mi[MI-1:0]];
        end
        if (i_cmd.bs_start) begin
            r_rd <= '0; r_wr <= '0;
        end
        if (!i_rst_n || i_cmd.bs_start) r_rdv <= 1'b0;
        else if (i_cmd.bs_step) r_rdv <= (r_rd < r_bcnt);
        if (i_cmd.bs_step) begin
            if (r_rd < r_bcnt) r_rd <= r_rd + BW'(1);
            if (r_rdv) begin
                if (r_rk == r_key) begin
                    r_bhit <= 1'b1; r_val <= r_rv; r_rdata <= r_rv;
                end else begin
                    r_wr <= r_wr + BW'(1);
                end
            end
        end
        if (i_cmd.vs_start) begin
            r_mi <= MW'(1); r_vi <= '0;
            if (!r_bhit && r_op != lps_pkg::OP_STORE) r_status <= lps_pkg::ST_MISS;
        end
        if (i_cmd.vs_step && !o_stat.vs_done) begin
            if (r_mstp[r_mi[MI-1:0]] < r_mstp[r_vi[MI-1:0]]) r_vi <= r_mi;
            r_mi <= w_next;
        end
        if (i_cmd.vpush) begin
            r_swapped <= 1'b1;
            r_ekey <= r_mkey[r_vi[MI-1:0]];
            if (!(r_bcnt < BW'(BACKING_ENTRIES))) r_status <= lps_pkg::ST_DROP;
            r_mi <= r_vi;
        end
        if (i_cmd.ms_start) r_mi <= r_mi;
        if (i_cmd.ms_step) begin
            if (!o_stat.ms_done) begin
                r_mkey[r_mi[MI-1:0]] <= r_mkey[w_next[MI-1:0]];
                r_mval[r_mi[MI-1:0]] <= r_mval[w_next[MI-1:0]];
                r_mstp[r_mi[MI-1:0]] <= r_mstp[w_next[MI-1:0]];
            end
            r_mi <= w_next;
        end
        if (i_cmd.append && r_mcnt < MW'(MAIN_ENTRIES)) begin
            r_mkey[r_mcnt[MI-1:0]] <= r_key;
            r_mval[r_mcnt[MI-1:0]] <= r_val;
            r_mstp[r_mcnt[MI-1:0]] <= r_now;
        end
        if (i_cmd.res_set) begin
            o_status <= r_status; o_swapped <= r_swapped; o_evicted_key <= r_ekey;
            o_rdata <= (r_op == lps_pkg::OP_LOOKUP) ? r_rdata : '0;
        end
        if (i_cmd.bs_step && r_rd >= r_bcnt && !r_rdv && r_op == lps_pkg::OP_RELEASE
            && !r_bhit) r_status <= lps_pkg::ST_MISS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0; r_bcnt <= '0;
        end else begin
            if (i_cmd.dec_main) r_mcnt <= r_mcnt - MW'(1);
            else if (i_cmd.append && r_mcnt < MW'(MAIN_ENTRIES)) r_mcnt <= r_mcnt + MW'(1);
            if (i_cmd.bs_step && r_rd >= r_bcnt && !r_rdv) r_bcnt <= r_wr;
            else if (i_cmd.vpush && r_bcnt < BW'(BACKING_ENTRIES)) r_bcnt <= r_bcnt + BW'(1);
        end
    end
endmodule

// ----- design/lru_page_store_with_backing.sv -----
// One request at a time; the next request can be taken in the cycle after the result is
// registered. A result that is not taken holds the block in its final state.
// Reset: synchronous active low; clears counts, state, result valid and sets r_pages to 16.
//------------------------------------------------------------------------------
// lru_page_store_with_backing
// Two-level LRU keyed store with a backing list.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_page_store_with_backing_assert.svh"
module lru_page_store_with_backing #(
    parameter int MAIN_ENTRIES    = lps_pkg::MAIN_ENTRIES_DEF,
    parameter int BACKING_ENTRIES = lps_pkg::BACKING_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    lps_req_if.sink    i_req,
    lps_res_if.source  o_res
);
    logic [4:0] r_pages;
    logic r_valid;
    logic w_busy, w_start, w_free;
    lps_pkg::t_cmd  w_cmd;
    lps_pkg::t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= 5'd16;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_pages <= i_cfg_wdata;
            if (w_cmd.res_set) r_valid <= 1'b1;
            else if (o_res.ready) r_valid <= 1'b0;
        end
    end

    assign i_req.ready = !w_busy;
    assign w_start = i_req.valid && !w_busy;
    assign w_free = !r_valid || o_res.ready;
    assign o_res.valid = r_valid;

    lps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_op(i_req.op),
        .i_res_free(w_free), .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    lps_dpath #(.MAIN_ENTRIES(MAIN_ENTRIES), .BACKING_ENTRIES(BACKING_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pages(r_pages),
        .i_op(i_req.op), .i_key(i_req.key), .i_wdata(i_req.wdata),
        .i_now(i_req.now), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_status(o_res.status), .o_rdata(o_res.rdata), .o_swapped(o_res.swapped),
        .o_evicted_key(o_res.evicted_key)
    );

    `LPS_ASSERT_NXT(a_res_after_set, i_clk, i_rst_n, w_cmd.res_set, o_res.valid)
    `LPS_ASSERT_IMP(a_no_start_busy, i_clk, i_rst_n, w_busy, !i_req.ready)
endmodule

// ----- verif/lps_tb_if.sv -----
//------------------------------------------------------------------------------
// lps_tb_if
// Configuration port bundle seen by the testbench checker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface lps_cfg_if;
    logic       we;
    logic [4:0] wdata;
    modport source (output we, wdata);
    modport sink (input we, wdata);
endinterface

// ----- verif/lps_checker.sv -----
//------------------------------------------------------------------------------
// lps_checker
// Watches the request, result and register channels of the LRU page store,
// keeps its own copy of the main store and the backing list, predicts the
// result of every accepted request and compares each result field by field.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module lps_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lps_cfg_if.sink    i_cfg,
    lps_req_if         i_req,
    lps_res_if         i_res,
    output int         o_fail_count,
    output int         o_pending
);
    localparam int MAIN_N = lps_pkg::MAIN_ENTRIES_DEF;
    localparam int BACK_N = lps_pkg::BACKING_ENTRIES_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rdata;
        logic        swapped;
        logic [31:0] evicted_key;
    } t_page_result;

    logic [4:0]  pages_cfg;
    logic [31:0] mkey [$];
    logic [31:0] mval [$];
    logic [30:0] mstamp [$];
    logic [31:0] bkey [$];
    logic [31:0] bval [$];
    t_page_result expected_results [$];

    function automatic int main_capacity();
        int c;
        c = pages_cfg;
        if (c < 1) c = 1;
        if (c > MAIN_N) c = MAIN_N;
        return c;
    endfunction

    function automatic int find_main(logic [31:0] k);
        foreach (mkey[i]) if (mkey[i] == k) return i;
        return -1;
    endfunction

    function automatic int pull_backing(logic [31:0] k, output logic [31:0] v);
        int hits;
        hits = 0;
        v = '0;
        for (int i = 0; i < bkey.size(); i++) begin
            if (bkey[i] == k) begin
                v = bval[i];
                bkey.delete(i);
                bval.delete(i);
                hits++;
                i--;
            end
        end
        return hits;
    endfunction

    function automatic void place_page(logic [31:0] k, logic [31:0] v, logic [30:0] t,
                                       ref t_page_result r);
        int vi;
        if (mkey.size() >= main_capacity() && mkey.size() > 0) begin
            vi = 0;
            foreach (mstamp[i]) if (mstamp[i] < mstamp[vi]) vi = i;
            r.swapped = 1'b1;
            r.evicted_key = mkey[vi];
            if (bkey.size() < BACK_N) begin
                bkey = {bkey, mkey[vi]};
                bval = {bval, mval[vi]};
            end else begin
                r.status = lps_pkg::ST_DROP;
            end
            mkey.delete(vi);
            mval.delete(vi);
            mstamp.delete(vi);
        end
        if (mkey.size() < MAIN_N) begin
            mkey = {mkey, k};
            mval = {mval, v};
            mstamp = {mstamp, t};
        end
    endfunction

    function automatic t_page_result predict_page_op(logic [1:0] op, logic [31:0] k,
                                                     logic [31:0] wd, logic [30:0] t);
        t_page_result r;
        int m;
        logic [31:0] v;
        r = '0;
        if (op == lps_pkg::OP_STORE) begin
            place_page(k, wd, t, r);
        end else if (op == lps_pkg::OP_RELEASE) begin
            m = find_main(k);
            if (m >= 0) begin
                mkey.delete(m);
                mval.delete(m);
                mstamp.delete(m);
            end else if (pull_backing(k, v) == 0) begin
                r.status = lps_pkg::ST_MISS;
            end
        end else if (op == lps_pkg::OP_LOOKUP) begin
            m = find_main(k);
            if (m >= 0) begin
                mstamp[m] = t;
                r.rdata = mval[m];
            end else if (pull_backing(k, v) == 0) begin
                r.status = lps_pkg::ST_MISS;
            end else begin
                place_page(k, v, t, r);
                r.rdata = v;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_page_result exp_r;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            pages_cfg <= 5'd16;
            mkey.delete();
            mval.delete();
            mstamp.delete();
            bkey.delete();
            bval.delete();
            expected_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg.we) pages_cfg <= i_cfg.wdata;
            if (i_req.valid && i_req.ready)
                expected_results = {expected_results,
                                    predict_page_op(i_req.op, i_req.key,
                                                    i_req.wdata, i_req.now)};
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    errs++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_res.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, i_res.status);
                        errs++;
                    end
                    if (i_res.rdata !== exp_r.rdata) begin
                        $error("rdata expected %h actual %h", exp_r.rdata, i_res.rdata);
                        errs++;
                    end
                    if (i_res.swapped !== exp_r.swapped) begin
                        $error("swapped expected %0d actual %0d", exp_r.swapped,
                               i_res.swapped);
                        errs++;
                    end
                    if (i_res.evicted_key !== exp_r.evicted_key) begin
                        $error("evicted_key expected %h actual %h", exp_r.evicted_key,
                               i_res.evicted_key);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= expected_results.size();
        end
    end
endmodule

// ----- verif/tb_lru_page_store_with_backing.sv -----
//------------------------------------------------------------------------------
// tb_lru_page_store_with_backing
// Drives directed and random store, release, lookup and no-op requests through the
// LRU page store under several capacities, with random gaps on both channels;
// the checker predicts every result and counts mismatches.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_lru_page_store_with_backing;
    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic [31:0] key_pool [8];

    lps_cfg_if cfg ();
    lps_req_if req ();
    lps_res_if res ();

    lru_page_store_with_backing uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg.we),
        .i_cfg_wdata(cfg.wdata),
        .i_req      (req),
        .o_res      (res)
    );

    lps_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_req        (req),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #300ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    initial begin
        res.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                res.ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] wd,
                                logic [30:0] t, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            req.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= k;
        req.wdata <= wd;
        req.now   <= t;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic drain_and_idle();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        drain_and_idle();
        cfg.we    <= 1'b1;
        cfg.wdata <= v;
        @(posedge i_clk);
        cfg.we    <= 1'b0;
    endtask

    task automatic random_phase(int n, int key_span);
        logic [1:0]  op;
        logic [31:0] k;
        logic [30:0] t;
        bit          burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            op = $urandom_range(0, 9) < 5 ? lps_pkg::OP_STORE
               : ($urandom_range(0, 2) == 0 ? lps_pkg::OP_RELEASE : lps_pkg::OP_LOOKUP);
            if ($urandom_range(0, 19) == 0) op = lps_pkg::OP_NOP;
            k = ($urandom_range(0, 9) == 0) ? $urandom()
              : key_pool[$urandom_range(0, key_span - 1)];
            t = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 15));
            send_request(op, k, $urandom(), t, burst);
            if (i == n / 2 && $urandom_range(0, 1) == 0) drain_and_idle();
        end
    endtask

    initial begin
        cfg.we    <= 1'b0;
        cfg.wdata <= 5'd0;
        req.valid <= 1'b0;
        req.op    <= lps_pkg::OP_STORE;
        req.key   <= '0;
        req.wdata <= '0;
        req.now   <= '0;
        i_rst_n   <= 1'b0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(lps_pkg::OP_LOOKUP, 32'h0, '0, 31'd0, 0);
        send_request(lps_pkg::OP_RELEASE, 32'hFFFF_FFFF, '0, 31'd0, 0);
        write_capacity(5'd2);
        send_request(lps_pkg::OP_STORE, 32'h0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        send_request(lps_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h0, 31'd5, 0);
        send_request(lps_pkg::OP_STORE, 32'h0, 32'h1234_5678, 31'd5, 0);
        send_request(lps_pkg::OP_STORE, 32'h11, 32'hAAAA_5555, 31'd9, 0);
        send_request(lps_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h5555_AAAA, 31'd1, 0);
        send_request(lps_pkg::OP_LOOKUP, 32'h0, '0, 31'd20, 0);
        send_request(lps_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, 31'd21, 0);
        send_request(lps_pkg::OP_RELEASE, 32'h11, '0, 31'd0, 0);
        send_request(lps_pkg::OP_RELEASE, 32'h0, '0, 31'd0, 0);
        send_request(lps_pkg::OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0);
        send_request(lps_pkg::OP_LOOKUP, 32'h7, '0, 31'd0, 0);
        write_capacity(5'd0);
        send_request(lps_pkg::OP_STORE, 32'h5, 32'h5, 31'd3, 0);
        send_request(lps_pkg::OP_STORE, 32'h6, 32'h6, 31'd3, 0);
        send_request(lps_pkg::OP_LOOKUP, 32'h5, '0, 31'd4, 0);
        write_capacity(5'd31);

        random_phase(60, 8);
        write_capacity(5'd1);
        for (int i = 0; i < 270; i++)
            send_request(lps_pkg::OP_STORE, i[31:0] & 32'h7, $urandom(),
                         31'($urandom()), 1);
        send_request(lps_pkg::OP_STORE, 32'h9, 32'h9, 31'd0, 0);
        send_request(lps_pkg::OP_LOOKUP, 32'h3, '0, 31'd1, 0);
        random_phase(40, 8);
        write_capacity(5'd16);
        random_phase(40, 8);
        write_capacity(5'd4);
        random_phase(40, 3);
        write_capacity(5'd17);
        random_phase(30, 8);

        drain_and_idle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
